// ===== src/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// rps_pkg: shared types and constants for the RTC prescaler search
// Register codes, field widths, select codes and the divider control structs.
// ----------------------------------------------------------------------------
package rps_pkg;

  localparam int FREQ_W       = 32;
  localparam int RATE_W       = 32;
  localparam int SRC_W        = 2;
  localparam int SEL_W        = 5;
  localparam int RELOAD_FW    = 20;
  localparam int CFG_IDX_W    = 2;
  localparam int NUM_SRC      = 4;

  localparam int DEF_RELOAD_WIDTH = 20;
  localparam int DEF_MAX_SELECT   = 15;

  localparam logic [SEL_W-1:0] SEL_BASE      = 5'd7;
  localparam logic [SEL_W-1:0] SEL_EXHAUSTED = 5'd16;

  // Configuration register indexes, which double as clock source codes.
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_LOW_INT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_LOW_EXT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_HIGH_INT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_HIGH_EXT = 2'd3;

  localparam logic [FREQ_W-1:0] RST_FREQ_LOW_INT  = 32'd40000;
  localparam logic [FREQ_W-1:0] RST_FREQ_LOW_EXT  = 32'd32768;
  localparam logic [FREQ_W-1:0] RST_FREQ_HIGH_INT = 32'd8000000;
  localparam logic [FREQ_W-1:0] RST_FREQ_HIGH_EXT = 32'd8000000;

  typedef logic [NUM_SRC-1:0][FREQ_W-1:0] freq_arr_t;

  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [FREQ_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/rps_if.sv =====
// ----------------------------------------------------------------------------
// rps_if: request and response channels of the RTC prescaler search
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface rps_req_if
  import rps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] wanted_rate;
  logic [SRC_W-1:0]  clock_source;

  modport source (output valid, output wanted_rate, output clock_source, input ready);
  modport sink   (input valid, input wanted_rate, input clock_source, output ready);
endinterface

interface rps_rsp_if
  import rps_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 status_ok;
  logic [SEL_W-1:0]     divider_select;
  logic [RELOAD_FW-1:0] reload_value;

  modport source (output valid, output status_ok, output divider_select,
                  output reload_value, input ready);
  modport sink   (input valid, input status_ok, input divider_select,
                  input reload_value, output ready);
endinterface

// ===== src/rps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rps_cfg_regs: clock source frequency registers
// Four 32-bit frequency registers written through a plain write port.
// ----------------------------------------------------------------------------
module rps_cfg_regs
  import rps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FREQ_W-1:0]    cfg_wdata,
  output freq_arr_t            freq
);

  freq_arr_t freq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r[REG_FREQ_LOW_INT]  <= RST_FREQ_LOW_INT;
      freq_r[REG_FREQ_LOW_EXT]  <= RST_FREQ_LOW_EXT;
      freq_r[REG_FREQ_HIGH_INT] <= RST_FREQ_HIGH_INT;
      freq_r[REG_FREQ_HIGH_EXT] <= RST_FREQ_HIGH_EXT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FREQ_LOW_INT:  freq_r[REG_FREQ_LOW_INT]  <= cfg_wdata;
        REG_FREQ_LOW_EXT:  freq_r[REG_FREQ_LOW_EXT]  <= cfg_wdata;
        REG_FREQ_HIGH_INT: freq_r[REG_FREQ_HIGH_INT] <= cfg_wdata;
        REG_FREQ_HIGH_EXT: freq_r[REG_FREQ_HIGH_EXT] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign freq = freq_r;

endmodule

// ===== src/rps_divider.sv =====
// ----------------------------------------------------------------------------
// rps_divider: radix-2 restoring divider
// One quotient bit per cycle; done pulses after the last quotient bit.
// ----------------------------------------------------------------------------
module rps_divider
  import rps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int DIV_STEPS = FREQ_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  logic [FREQ_W-1:0] rem_r, rem_nxt;
  logic [FREQ_W-1:0] quo_r, quo_nxt;
  logic [RATE_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;

  logic [FREQ_W:0]   trial;
  logic [FREQ_W:0]   diff;
  logic              fits;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial   = {rem_r, quo_r[FREQ_W-1]};
    diff    = trial - {1'b0, dvs_r};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
    quo_nxt = {quo_r[FREQ_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_STEPS);
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== src/rtc_prescaler_search_top.sv =====
// ----------------------------------------------------------------------------
// rtc_prescaler_search_top: prescaler select and reload search for an RTC tick
// Divides the source frequency by the wanted rate, then walks the selects.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction on in_req carries the wanted tick rate and a clock
// source code. The source frequency comes from the four registers written on
// the cfg_ port. One response transaction on out_rsp follows each request and
// carries the ok flag, the pre-divider select and the saturated reload value.
// The block handles one request at a time and in_req.ready is low while it
// works. A nonzero rate passes the accepting cycle, the shared restoring
// divider, the capture of the quotient, the select search (one shift and
// range compare per cycle, on the same quotient register) and the load of the
// output register. The next request can be accepted once the output register
// is loaded. A zero rate skips the divider and the search and goes straight
// to the output register.
// The search relies on floor(clk / (rate << k)) being equal to
// floor(clk / rate) >> k, so only one division is done per request.
// A synchronous low rst_n returns the registers to their default
// frequencies and empties the pipeline. If the receiver stalls, the result
// waits in the output register; the next request may already be accepted and
// worked on, and it waits in turn until the output register is free.
// ----------------------------------------------------------------------------
module rtc_prescaler_search_top
  import rps_pkg::*;
#(
  parameter int RELOAD_WIDTH = DEF_RELOAD_WIDTH,
  parameter int MAX_SELECT   = DEF_MAX_SELECT
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  rps_req_if.sink              in_req,
  rps_rsp_if.source            out_rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FREQ_W-1:0]    cfg_wdata
);

  // Largest reload value that the prescaler counter can hold.
  localparam logic [FREQ_W:0] RELOAD_MAX = (33'd1 << RELOAD_WIDTH) - 33'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_SEARCH,
    S_EMIT
  } state_t;

  state_t               state_r;
  logic                 fast_r;
  logic [FREQ_W-1:0]    q_r;
  logic [SEL_W-1:0]     sel_r;
  logic                 ok_r;

  logic                 out_valid_r;
  logic                 out_ok_r;
  logic [SEL_W-1:0]     out_sel_r;
  logic [RELOAD_FW-1:0] out_reload_r;

  freq_arr_t            freq;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic                 in_fire;
  logic                 out_fire;
  logic                 emit_load;
  logic                 q_in_range;
  logic [FREQ_W-1:0]    q_sat;

  rps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .freq      (freq)
  );

  rps_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_fire     = out_valid_r && out_rsp.ready;

  // The output register takes a new result when it is empty or being drained.
  assign emit_load    = (state_r == S_EMIT) && (!out_valid_r || out_rsp.ready);

  // The division starts in the same cycle the request is accepted.
  assign div_req.start    = in_fire && (in_req.wanted_rate != '0);
  assign div_req.dividend = freq[in_req.clock_source];
  assign div_req.divisor  = in_req.wanted_rate;

  // Shared range check and saturation on the quotient register.
  assign q_in_range = (q_r != '0) && ({1'b0, q_r} <= RELOAD_MAX);
  assign q_sat      = ({1'b0, q_r} > RELOAD_MAX) ? RELOAD_MAX[FREQ_W-1:0] : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            fast_r <= in_req.clock_source[SRC_W-1];
            sel_r  <= SEL_BASE;
            if (in_req.wanted_rate == '0) begin
              // Zero rate fails at once with select 7 and no reload.
              q_r     <= '0;
              ok_r    <= 1'b0;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_DIVIDE;
            end
          end
        end
        S_DIVIDE: begin
          if (div_rsp.done) begin
            q_r     <= div_rsp.quotient;
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (q_in_range) begin
            ok_r    <= 1'b1;
            state_r <= S_EMIT;
          end else if (!fast_r) begin
            // Slow sources have only select 7 to offer.
            ok_r    <= 1'b0;
            state_r <= S_EMIT;
          end else if (sel_r == SEL_W'(MAX_SELECT)) begin
            // Out of selects; the reload of the last select is reported.
            ok_r    <= 1'b0;
            sel_r   <= SEL_EXHAUSTED;
            state_r <= S_EMIT;
          end else begin
            q_r   <= q_r >> 1;
            sel_r <= sel_r + SEL_W'(1);
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            out_ok_r     <= ok_r;
            out_sel_r    <= sel_r;
            out_reload_r <= q_sat[RELOAD_FW-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status_ok      = out_ok_r;
  assign out_rsp.divider_select = out_sel_r;
  assign out_rsp.reload_value   = out_reload_r;

`ifndef SYNTHESIS
  // A zero-rate request goes straight to the output stage.
  a_zero_rate_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_req.wanted_rate == '0) |=> (state_r == S_EMIT))
    else $error("zero-rate request did not go straight to the output stage");

  // The divider is only started from idle and never while it is busy.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (state_r == S_IDLE) && !div_rsp.busy)
    else $error("divider started outside of idle");

  // A successful result carries a select inside the searched range.
  a_ok_select_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ok_r |->
      (out_sel_r >= SEL_BASE) && (out_sel_r <= SEL_W'(MAX_SELECT)))
    else $error("successful result with a select outside the search range");

  // The divider reports done only while the sequencer waits for it.
  a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIVIDE))
    else $error("divider finished while the sequencer was not waiting");
`endif

endmodule
